// File: design/coalescing_change_list_top_macros.svh
// Assertion macros for the checker file of the change list.
`ifndef COALESCING_CHANGE_LIST_TOP_MACROS_SVH
`define COALESCING_CHANGE_LIST_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CCL_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ccl_pkg.sv
// ----------------------------------------------------------------------------
// ccl_pkg
// Codes, field layout and cell control type of the coalescing change list.
// ----------------------------------------------------------------------------
`default_nettype none

package ccl_pkg;

	typedef logic [1:0] kind_t;
	typedef logic [1:0] status_t;

	localparam kind_t KIND_APPEND = 2'd0;
	localparam kind_t KIND_READ   = 2'd1;
	localparam kind_t KIND_CLEAR  = 2'd2;

	localparam status_t STATUS_OK      = 2'd0;
	localparam status_t STATUS_ILLEGAL = 2'd1;
	localparam status_t STATUS_FULL    = 2'd2;

	// tdata layout, same on both sides
	localparam int DATA_BITS   = 72;
	localparam int TAG_FIELD   = 16;
	localparam int HINT_FIELD  = 32;
	localparam int INDEX_FIELD = 6;
	localparam int MASK_BITS   = 32;

	// Broadcast control for the row of cells
	typedef struct packed {
		logic shift;  // cells at or above pos take their upper neighbor
		logic load;   // cell at pos takes the new record
		logic merge;  // cell at pos ORs the new hints in
	} cell_cmd_t;

endpackage

`default_nettype wire

// File: design/ccl_cell.sv
// ----------------------------------------------------------------------------
// ccl_cell
// One record slot of the change list: holds a record, compares its content
// tag, and shifts down from its upper neighbor when a record at or below it drops.
// ----------------------------------------------------------------------------
`default_nettype none

module ccl_cell #(
	parameter int TAG_BITS  = 16,
	parameter int HINT_BITS = 32,
	parameter int CNT_W     = 6,
	parameter int INDEX     = 0
) (
	input  wire logic                  clk,
	input  wire ccl_pkg::cell_cmd_t    cmd,
	input  wire logic [CNT_W-1:0]      pos,
	input  wire logic [TAG_BITS-1:0]   new_frame,
	input  wire logic [TAG_BITS-1:0]   new_content,
	input  wire logic [HINT_BITS-1:0]  new_hint,
	input  wire logic [TAG_BITS-1:0]   nbr_frame,
	input  wire logic [TAG_BITS-1:0]   nbr_content,
	input  wire logic [HINT_BITS-1:0]  nbr_hint,
	input  wire logic [TAG_BITS-1:0]   target,
	output logic      [TAG_BITS-1:0]   frame,
	output logic      [TAG_BITS-1:0]   content,
	output logic      [HINT_BITS-1:0]  hint,
	output logic                       match
);

	logic [TAG_BITS-1:0]  frame_q;
	logic [TAG_BITS-1:0]  content_q;
	logic [HINT_BITS-1:0] hint_q;
	logic                 at_pos;
	logic                 above_pos;

	assign at_pos    = (pos == CNT_W'(INDEX));
	assign above_pos = (pos <= CNT_W'(INDEX));

	always_ff @(posedge clk) begin
		if (cmd.shift && above_pos) begin
			frame_q   <= nbr_frame;
			content_q <= nbr_content;
			hint_q    <= nbr_hint;
		end else if (cmd.load && at_pos) begin
			frame_q   <= new_frame;
			content_q <= new_content;
			hint_q    <= new_hint;
		end else if (cmd.merge && at_pos) begin
			hint_q <= hint_q | new_hint;
		end
	end

	assign frame   = frame_q;
	assign content = content_q;
	assign hint    = hint_q;
	assign match   = (content_q == target);

endmodule

`default_nettype wire

// File: design/coalescing_change_list_top.sv
// ----------------------------------------------------------------------------
// coalescing_change_list_top
// Ordered list of change records with content removal and frame coalescing.
// ----------------------------------------------------------------------------
// The list lives in a row of LIST_DEPTH cells, one record each. A read, a
// clear, an unused kind and an append with no scan go from capture straight
// to ST_FINISH, which waits until the output register is free. An append
// whose hints hit reconstruct_mask with a non-null content tag, while the
// list holds records, first runs a removal scan down the row in ST_SCAN: each
// cycle either steps past one record or drops the matching record under the
// scan pointer while every cell above shifts down by one. One item is in
// work at a time; the result sits in an output register, and the next item
// may be taken while it waits.
// The reconstruct mask is written through the cfg channel, always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module coalescing_change_list_top #(
	parameter int LIST_DEPTH = 32,
	parameter int TAG_BITS   = 16,
	parameter int HINT_BITS  = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: reconstruct_mask
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [15:0] frame_tag, [31:16] content_tag, [63:32] hint_bits,
	// [69:64] read_index, [71:70] zero
	input  wire logic [71:0] s_tdata,
	// [1:0] kind
	input  wire logic [1:0]  s_tuser,
	// results
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [15:0] out_frame, [31:16] out_content, [63:32] out_hint,
	// [69:64] entry_count, [71:70] zero
	output logic [71:0]      m_tdata,
	// [1:0] status
	output logic [1:0]       m_tuser
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int IDX_W = $clog2(LIST_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         pos_q;
	logic [ccl_pkg::MASK_BITS-1:0] mask_q;
	logic                     m_tvalid_q;
	logic [ccl_pkg::DATA_BITS-1:0] m_tdata_q;
	ccl_pkg::status_t         m_tuser_q;

	ccl_pkg::kind_t           kind_q;
	logic [TAG_BITS-1:0]      frame_q;
	logic [TAG_BITS-1:0]      content_q;
	logic [HINT_BITS-1:0]     hint_q;
	logic [ccl_pkg::INDEX_FIELD-1:0] idx_q;

	logic [TAG_BITS-1:0]      in_frame;
	logic [TAG_BITS-1:0]      in_content;
	logic [HINT_BITS-1:0]     in_hint;
	logic                     s_accept;
	logic                     need_scan;
	logic                     out_free;
	logic                     finish_now;
	logic [CNT_W-1:0]         cnt_m1;
	logic [IDX_W-1:0]         rd_addr;
	logic                     read_ok;
	logic                     merge_hit;
	logic                     list_full;
	logic                     scan_done;
	logic                     scan_match;

	logic [TAG_BITS-1:0]      cell_frame   [LIST_DEPTH];
	logic [TAG_BITS-1:0]      cell_content [LIST_DEPTH];
	logic [HINT_BITS-1:0]     cell_hint    [LIST_DEPTH];
	logic [LIST_DEPTH-1:0]    match_vec;
	ccl_pkg::cell_cmd_t       cell_cmd;
	logic [CNT_W-1:0]         cell_pos;

	logic [TAG_BITS-1:0]      rd_frame;
	logic [TAG_BITS-1:0]      rd_content;
	logic [HINT_BITS-1:0]     rd_hint;

	ccl_pkg::status_t         res_status;
	logic [TAG_BITS-1:0]      res_frame;
	logic [TAG_BITS-1:0]      res_content;
	logic [HINT_BITS-1:0]     res_hint;
	logic [CNT_W-1:0]         res_count;

	// Input unpacking
	assign in_frame   = TAG_BITS'(s_tdata[15:0]);
	assign in_content = TAG_BITS'(s_tdata[31:16]);
	assign in_hint    = HINT_BITS'(s_tdata[63:32]);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign finish_now = (state_q == ST_FINISH) && out_free;

	assign need_scan = (s_tuser == ccl_pkg::KIND_APPEND) &&
		(|(ccl_pkg::MASK_BITS'(in_hint) & mask_q)) &&
		(in_content != '0) && (count_q != '0);

	// Shared record read: read index, or the last record for a merge check
	assign cnt_m1  = count_q - CNT_W'(1);
	assign rd_addr = (kind_q == ccl_pkg::KIND_READ) ? idx_q[IDX_W-1:0] : cnt_m1[IDX_W-1:0];
	assign rd_frame   = cell_frame[rd_addr];
	assign rd_content = cell_content[rd_addr];
	assign rd_hint    = cell_hint[rd_addr];

	assign read_ok   = (32'(idx_q) < 32'(count_q));
	assign merge_hit = (count_q != '0) && (frame_q != '0) && (rd_frame == frame_q);
	assign list_full = (count_q == CNT_W'(LIST_DEPTH));

	assign scan_done  = (pos_q >= count_q);
	assign scan_match = match_vec[pos_q[IDX_W-1:0]];

	always_comb begin
		cell_cmd.shift = (state_q == ST_SCAN) && !scan_done && scan_match;
		cell_cmd.load  = finish_now && (kind_q == ccl_pkg::KIND_APPEND) &&
			!merge_hit && !list_full;
		cell_cmd.merge = finish_now && (kind_q == ccl_pkg::KIND_APPEND) && merge_hit;
		if (state_q == ST_SCAN) begin
			cell_pos = pos_q;
		end else if (merge_hit) begin
			cell_pos = cnt_m1;
		end else begin
			cell_pos = count_q;
		end
	end

	// Row of cells; each takes from its upper neighbor on a shift
	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		localparam int NBR = (i == LIST_DEPTH - 1) ? i : i + 1;
		ccl_cell #(
			.TAG_BITS  (TAG_BITS),
			.HINT_BITS (HINT_BITS),
			.CNT_W     (CNT_W),
			.INDEX     (i)
		) u_cell (
			.clk         (clk),
			.cmd         (cell_cmd),
			.pos         (cell_pos),
			.new_frame   (frame_q),
			.new_content (content_q),
			.new_hint    (hint_q),
			.nbr_frame   (cell_frame[NBR]),
			.nbr_content (cell_content[NBR]),
			.nbr_hint    (cell_hint[NBR]),
			.target      (content_q),
			.frame       (cell_frame[i]),
			.content     (cell_content[i]),
			.hint        (cell_hint[i]),
			.match       (match_vec[i])
		);
	end

	// Result of the held command
	always_comb begin
		res_status  = ccl_pkg::STATUS_OK;
		res_frame   = '0;
		res_content = '0;
		res_hint    = '0;
		res_count   = count_q;
		case (kind_q)
			ccl_pkg::KIND_APPEND: begin
				if (!merge_hit) begin
					if (list_full) begin
						res_status = ccl_pkg::STATUS_FULL;
					end else begin
						res_count = count_q + CNT_W'(1);
					end
				end
			end
			ccl_pkg::KIND_READ: begin
				if (read_ok) begin
					res_frame   = rd_frame;
					res_content = rd_content;
					res_hint    = rd_hint;
				end else begin
					res_status = ccl_pkg::STATUS_ILLEGAL;
				end
			end
			ccl_pkg::KIND_CLEAR: begin
				res_count = '0;
			end
			default: begin
				res_count = count_q;
			end
		endcase
	end

	// Command capture
	always_ff @(posedge clk) begin
		if (s_accept) begin
			kind_q    <= s_tuser;
			frame_q   <= in_frame;
			content_q <= in_content;
			hint_q    <= in_hint;
			idx_q     <= s_tdata[69:64];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= ccl_pkg::MASK_BITS'(1024);
		end else if (cfg_valid) begin
			mask_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			pos_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= ccl_pkg::STATUS_OK;
		end else begin
			if (m_tready && !finish_now) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						pos_q   <= '0;
						state_q <= need_scan ? ST_SCAN : ST_FINISH;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_FINISH;
					end else if (scan_match) begin
						// drop the record under the pointer, hold the pointer
						count_q <= cnt_m1;
					end else begin
						pos_q <= pos_q + CNT_W'(1);
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= res_status;
						m_tdata_q  <= {2'b00, ccl_pkg::INDEX_FIELD'(res_count),
							ccl_pkg::HINT_FIELD'(res_hint),
							ccl_pkg::TAG_FIELD'(res_content),
							ccl_pkg::TAG_FIELD'(res_frame)};
						count_q    <= res_count;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// File: design/ccl_assert_mon.sv
// ----------------------------------------------------------------------------
// ccl_assert_mon
// Port-level checks on the result channel of the change list.
// ----------------------------------------------------------------------------
`default_nettype none

`include "coalescing_change_list_top_macros.svh"

module ccl_assert_mon #(
	parameter int LIST_DEPTH = 32
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [71:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	`CCL_ASSERT_HOLDS(a_count_bound, clk, arst_n, m_tvalid, 32'(m_tdata[69:64]) <= LIST_DEPTH, "entry count beyond list depth")
	`CCL_ASSERT_HOLDS(a_full_count, clk, arst_n, m_tvalid && (m_tuser == ccl_pkg::STATUS_FULL), m_tdata[69:64] == 6'(LIST_DEPTH), "full status with list not full")
	`CCL_ASSERT_HOLDS(a_illegal_zero, clk, arst_n, m_tvalid && (m_tuser == ccl_pkg::STATUS_ILLEGAL), m_tdata[63:0] == 64'd0, "illegal index result carries data")
	`CCL_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind coalescing_change_list_top ccl_assert_mon #(
	.LIST_DEPTH (LIST_DEPTH)
) u_assert_mon (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the coalescing change list. A queue-fed driver
// sends appends, reads, clears and unused kinds over the input stream,
// while a scoreboard model of the record list predicts every result. A
// monitor compares each result transfer with the oldest prediction. Both
// stream sides idle at random. The receiver also holds off for long
// stretches, and the reconstruct mask is rewritten between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ccl_pkg::*;

	localparam int LIST_DEPTH   = 32;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS  = 170;
	localparam int HOLD_CYCLES  = 400;

	// kind 3 has no operation behind it
	localparam kind_t KIND_UNUSED = 2'd3;

	typedef struct {
		kind_t       kind;
		logic [15:0] frame;
		logic [15:0] content;
		logic [31:0] hint;
		logic [5:0]  index;
	} change_op_t;

	typedef struct {
		status_t     status;
		logic [15:0] frame;
		logic [15:0] content;
		logic [31:0] hint;
		logic [5:0]  count;
	} list_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;

	coalescing_change_list_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// scoreboard copy of the record list
	logic [15:0] list_frame   [LIST_DEPTH];
	logic [15:0] list_content [LIST_DEPTH];
	logic [31:0] list_hint    [LIST_DEPTH];
	int          list_len = 0;
	logic [31:0] recon_mask = 32'd1024;

	change_op_t  pending_ops [$];
	list_reply_t expected_replies [$];

	change_op_t  cur_op;
	int          tx_gap = 0;
	int          rx_gap = 0;
	int          accepted_items = 0;
	int          hold_left = 0;
	int          next_hold = 300;
	int          err_count = 0;
	int          cycle_count = 0;
	bit          quiet = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic list_reply_t apply_change(input change_op_t op);
		list_reply_t rep;
		int wr;
		rep = '{status: STATUS_OK, frame: '0, content: '0, hint: '0, count: '0};
		case (op.kind)
			KIND_APPEND: begin
				if ((op.hint & recon_mask) != 0 && op.content != 0 && list_len > 0) begin
					// drop same-content records, keep the order of the rest
					wr = 0;
					for (int rd = 0; rd < list_len; rd++) begin
						if (list_content[rd] != op.content) begin
							list_frame[wr]   = list_frame[rd];
							list_content[wr] = list_content[rd];
							list_hint[wr]    = list_hint[rd];
							wr++;
						end
					end
					list_len = wr;
				end
				if (list_len > 0 && op.frame != 0 && list_frame[list_len-1] == op.frame) begin
					list_hint[list_len-1] |= op.hint;
				end else if (list_len >= LIST_DEPTH) begin
					rep.status = STATUS_FULL;
				end else begin
					list_frame[list_len]   = op.frame;
					list_content[list_len] = op.content;
					list_hint[list_len]    = op.hint;
					list_len++;
				end
			end
			KIND_READ: begin
				if (op.index < list_len) begin
					rep.frame   = list_frame[op.index];
					rep.content = list_content[op.index];
					rep.hint    = list_hint[op.index];
				end else begin
					rep.status = STATUS_ILLEGAL;
				end
			end
			KIND_CLEAR: list_len = 0;
			default: ;
		endcase
		rep.count = list_len[5:0];
		return rep;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin : driver
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_replies.push_back(apply_change(cur_op));
				accepted_items <= accepted_items + 1;
				tx_gap = pick_gap();
			end
			// hold the offered item until it transfers
			if (!(s_tvalid && !s_tready)) begin
				if (tx_gap != 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() != 0) begin
					cur_op = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {2'b00, cur_op.index, cur_op.hint, cur_op.content, cur_op.frame};
					s_tuser  <= cur_op.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin : hold_off
		if (!arst_n) begin
			hold_left <= 0;
			next_hold <= 300;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (accepted_items >= next_hold) begin
			hold_left <= HOLD_CYCLES;
			next_hold <= next_hold + 450;
		end
	end

	// result monitor and ready generator
	always @(posedge clk or negedge arst_n) begin : monitor
		list_reply_t exp_rep;
		logic [71:0] exp_data;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_replies.size() == 0) begin
					if (err_count < 10)
						$display("unexpected result: status %0d data %h", m_tuser, m_tdata);
					err_count++;
				end else begin
					exp_rep  = expected_replies.pop_front();
					exp_data = {2'b00, exp_rep.count, exp_rep.hint, exp_rep.content, exp_rep.frame};
					if (m_tdata !== exp_data || m_tuser !== exp_rep.status) begin
						if (err_count < 10) begin
							$write("mismatch (exp/act): status %0d/%0d frame %h/%h ",
								exp_rep.status, m_tuser, exp_rep.frame, m_tdata[15:0]);
							$display("content %h/%h hint %h/%h count %0d/%0d pad %b",
								exp_rep.content, m_tdata[31:16], exp_rep.hint, m_tdata[63:32],
								exp_rep.count, m_tdata[69:64], m_tdata[71:70]);
						end
						err_count++;
					end
				end
				rx_gap = pick_gap();
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** coalescing_change_list_top: FAILED **");
			$finish;
		end
	end

	task automatic push_op(input kind_t k, input logic [15:0] f, input logic [15:0] c,
			input logic [31:0] h, input logic [5:0] i);
		change_op_t op;
		op = '{kind: k, frame: f, content: c, hint: h, index: i};
		pending_ops.push_back(op);
	endtask

	function automatic logic [31:0] plain_hint();
		return $urandom & ~recon_mask;
	endfunction

	function automatic logic [31:0] rebuild_hint();
		logic [31:0] h;
		h = $urandom;
		if ((h & recon_mask) == 0)
			h |= recon_mask & (~recon_mask + 32'd1);
		return h;
	endfunction

	function automatic logic [15:0] pool_tag(input int top);
		return 16'($urandom_range(0, top));
	endfunction

	// clear, then append past the depth, then probe the full list
	task automatic gen_fill();
		int n;
		logic [15:0] last_f;
		logic [15:0] f;
		push_op(KIND_CLEAR, '0, '0, '0, '0);
		n = $urandom_range(34, 44);
		last_f = '0;
		for (int k = 0; k < n; k++) begin
			f = ($urandom_range(0, 9) == 0) ? last_f : pool_tag(12);
			push_op(KIND_APPEND, f, pool_tag(8), plain_hint(), '0);
			last_f = f;
		end
		push_op(KIND_APPEND, last_f, pool_tag(8), plain_hint(), '0);
		for (int k = 0; k < 4; k++)
			push_op(KIND_READ, '0, '0, '0, 6'($urandom_range(0, 40)));
		push_op(KIND_APPEND, pool_tag(12), pool_tag(8), rebuild_hint(), '0);
		push_op(KIND_READ, '0, '0, '0, 6'($urandom_range(0, 33)));
	endtask

	// mostly well-formed traffic on small tag pools, with an occasional unused kind
	task automatic gen_mixed();
		int r;
		for (int k = 0; k < 12; k++) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				push_op(KIND_APPEND, pool_tag(8), pool_tag(8), plain_hint(), '0);
			else if (r < 60)
				push_op(KIND_APPEND, pool_tag(8), pool_tag(8), rebuild_hint(), '0);
			else if (r < 94)
				push_op(KIND_READ, '0, '0, '0, 6'($urandom_range(0, 35)));
			else if (r < 97)
				push_op(KIND_CLEAR, '0, '0, '0, '0);
			else
				push_op(KIND_UNUSED, 16'($urandom), 16'($urandom), $urandom, 6'($urandom));
		end
	endtask

	// fully random fields
	task automatic gen_noise();
		for (int k = 0; k < 6; k++)
			push_op(kind_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), $urandom,
				6'($urandom));
	endtask

	task automatic write_mask(input logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		recon_mask = value;
	endtask

	task automatic wait_drain();
		while (pending_ops.size() != 0 || s_tvalid || expected_replies.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		logic [31:0] masks [6];
		int start_len;
		int r;
		masks[0] = 32'd1024;
		masks[1] = 32'h0000_0000;
		masks[2] = 32'hffff_ffff;
		masks[3] = $urandom;
		masks[4] = 32'h0000_0001;
		masks[5] = 32'h8000_0000;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corner cases under the reset mask
		push_op(KIND_READ, '0, '0, '0, 6'd0);
		push_op(KIND_APPEND, '0, '0, '0, '0);
		push_op(KIND_APPEND, '0, 16'h0005, 32'h1, '0);
		push_op(KIND_APPEND, 16'hffff, 16'hffff, 32'hffff_ffff, '0);
		push_op(KIND_APPEND, 16'hffff, 16'h0001, 32'h2, '0);
		push_op(KIND_READ, '0, '0, '0, 6'd2);
		push_op(KIND_READ, '0, '0, '0, 6'd63);
		push_op(KIND_APPEND, 16'h0007, 16'h0005, 32'h400, '0);
		push_op(KIND_APPEND, 16'h0009, '0, 32'h400, '0);
		push_op(KIND_UNUSED, 16'hffff, 16'hffff, 32'hffff_ffff, 6'd63);
		push_op(KIND_READ, '0, '0, '0, 6'd0);
		push_op(KIND_READ, '0, '0, '0, 6'd1);
		push_op(KIND_READ, '0, '0, '0, 6'd3);
		push_op(KIND_READ, '0, '0, '0, 6'd4);
		push_op(KIND_APPEND, 16'h0009, '0, 32'h0000_ffff, '0);
		push_op(KIND_READ, 16'hffff, 16'hffff, 32'hffff_ffff, 6'd3);
		push_op(KIND_CLEAR, 16'hffff, 16'hffff, 32'hffff_ffff, 6'd63);
		push_op(KIND_READ, '0, '0, '0, 6'd0);
		push_op(KIND_APPEND, '0, '0, 32'hffff_ffff, '0);
		wait_drain();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph != 0)
				write_mask(masks[ph]);
			@(negedge clk);
			quiet = (ph == 2);
			start_len = pending_ops.size();
			while (pending_ops.size() - start_len < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 25)
					gen_fill();
				else if (r < 85)
					gen_mixed();
				else
					gen_noise();
			end
			// pause the sender until every result of the phase is back
			wait_drain();
		end

		if (err_count == 0)
			$display("** coalescing_change_list_top: PASSED **");
		else
			$display("** coalescing_change_list_top: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

// File: coalescing_change_list_top.f
+incdir+design
design/ccl_pkg.sv
design/ccl_cell.sv
design/coalescing_change_list_top.sv
design/ccl_assert_mon.sv
sim/tb_top.sv
